// ----- sv/hashed_list_store_unit_assert.svh -----
// Assertion macros used by hashed_list_store_unit.sv.
`ifndef HASHED_LIST_STORE_UNIT_ASSERT_SVH
`define HASHED_LIST_STORE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define HLS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("hashed_list_store_unit assertion failed");
`define HLS_ASSERT_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
	else $error("hashed_list_store_unit forbidden condition");
`else
`define HLS_ASSERT(lbl, prop)
`define HLS_ASSERT_NEVER(lbl, expr)
`endif
`endif

// ----- sv/hls_pkg.sv -----
package hls_pkg;
	localparam int MAX_ITEMS = 64;
	localparam int CNT_W = $clog2(MAX_ITEMS + 1);
	localparam int ADDR_W = $clog2(MAX_ITEMS);
	localparam int VAL_W = 31;
	localparam int HASH_W = 30;
	localparam int BIT_W = $clog2(HASH_W);
	localparam logic [HASH_W-1:0] HASH_MOD = 30'd1000000009;
	localparam logic [HASH_W-1:0] BASE_RESET = 30'd37;

	typedef enum logic [1:0] {
		K_APPEND = 2'd0,
		K_FIND = 2'd1,
		K_REMOVE = 2'd2,
		K_COMPARE = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_FULL = 2'd1,
		ST_ABSENT = 2'd2
	} status_t;

	// Brings a value below four times the modulus back into range.
	function automatic logic [HASH_W-1:0] mod_reduce(input logic [32:0] x);
		logic [32:0] m1;
		logic [32:0] m2;
		logic [32:0] m3;
		logic [32:0] d;
		m1 = {3'b000, HASH_MOD};
		m2 = m1 << 1;
		m3 = m1 + m2;
		if (x >= m3) begin
			d = x - m3;
		end else if (x >= m2) begin
			d = x - m2;
		end else if (x >= m1) begin
			d = x - m1;
		end else begin
			d = x;
		end
		return d[HASH_W-1:0];
	endfunction
endpackage

// ----- sv/hls_req_if.sv -----
interface hls_req_if import hls_pkg::*; ();
	logic valid;
	logic ready;
	logic [1:0] kind;
	logic [VAL_W-1:0] item_value;
	logic [6:0] other_length;
	logic [HASH_W-1:0] other_hash;
	modport source (output valid, kind, item_value, other_length, other_hash, input ready);
	modport sink (input valid, kind, item_value, other_length, other_hash, output ready);
endinterface

// ----- sv/hls_rsp_if.sv -----
interface hls_rsp_if import hls_pkg::*; ();
	logic valid;
	logic ready;
	logic [1:0] status;
	logic found;
	logic equal;
	logic [6:0] list_length;
	logic [HASH_W-1:0] list_hash;
	modport source (output valid, status, found, equal, list_length, list_hash, input ready);
	modport sink (input valid, status, found, equal, list_length, list_hash, output ready);
endinterface

// ----- sv/hls_ram.sv -----
module hls_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ----- sv/hashed_list_store_unit.sv -----
// Append: one 30-step shift-add modular multiply, then the add.
// Find: a read and a compare per entry scanned; compare: no scan, checks length and hash.
// Remove: a read and a compare per entry to scan, a read and a write per entry to shift,
// then one multiply and add per remaining entry to rehash; the modular multiplier dominates.
// One command at a time. Reset clears the count and hash and sets the base to 37;
// the value store is not cleared.
`include "hashed_list_store_unit_assert.svh"
module hashed_list_store_unit import hls_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [HASH_W-1:0] cfg_wdata,
	hls_req_if.sink req,
	hls_rsp_if.source rsp
);
	typedef enum logic [10:0] {
		S_IDLE     = 11'b00000000001,
		S_SCAN_RD  = 11'b00000000010,
		S_SCAN_CMP = 11'b00000000100,
		S_SH_RD    = 11'b00000001000,
		S_SH_WR    = 11'b00000010000,
		S_REH      = 11'b00000100000,
		S_H_RD     = 11'b00001000000,
		S_H_LD     = 11'b00010000000,
		S_MUL      = 11'b00100000000,
		S_ADD      = 11'b01000000000,
		S_DONE     = 11'b10000000000
	} state_t;

	state_t state_q;
	kind_t kind_q;
	logic [VAL_W-1:0] val_q;
	logic [HASH_W-1:0] base_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] idx_q;
	logic [HASH_W-1:0] hash_q;
	logic [HASH_W-1:0] r_q;
	logic [BIT_W-1:0] bit_q;
	logic [VAL_W-1:0] addv_q;
	status_t status_q;
	logic found_q;
	logic equal_q;
	logic outv_q;
	logic [1:0] ost_q;
	logic ofound_q;
	logic oequal_q;
	logic [6:0] olength_q;
	logic [HASH_W-1:0] ohash_out_q;

	logic ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [VAL_W-1:0] ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [VAL_W-1:0] ram_rdata;
	logic [CNT_W-1:0] idx_inc;
	logic [32:0] mul_sum;
	logic [32:0] add_sum;
	logic [HASH_W-1:0] mul_red;
	logic [HASH_W-1:0] add_red;

	hls_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ITEMS)) u_store (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	assign idx_inc = idx_q + 1'b1;
	assign mul_sum = {2'b00, r_q, 1'b0} + (base_q[bit_q] ? {3'b000, hash_q} : 33'd0);
	assign add_sum = {3'b000, r_q} + {2'b00, addv_q};
	assign mul_red = mod_reduce(mul_sum);
	assign add_red = mod_reduce(add_sum);

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = cnt_q[ADDR_W-1:0];
		ram_wdata = req.item_value;
		ram_raddr = idx_q[ADDR_W-1:0];
		case (state_q)
			S_IDLE: begin
				ram_we = req.valid && kind_t'(req.kind) == K_APPEND
					&& cnt_q != CNT_W'(MAX_ITEMS);
			end
			S_SH_RD: ram_raddr = idx_inc[ADDR_W-1:0];
			S_SH_WR: begin
				ram_we = 1'b1;
				ram_waddr = idx_q[ADDR_W-1:0];
				ram_wdata = ram_rdata;
			end
			default: ;
		endcase
	end

	assign req.ready = state_q == S_IDLE;
	assign rsp.valid = outv_q;
	assign rsp.status = ost_q;
	assign rsp.found = ofound_q;
	assign rsp.equal = oequal_q;
	assign rsp.list_length = olength_q;
	assign rsp.list_hash = ohash_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			base_q <= BASE_RESET;
			cnt_q <= '0;
			hash_q <= '0;
			outv_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				base_q <= cfg_wdata;
			end
			if (outv_q && rsp.ready && state_q != S_DONE) begin
				outv_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						kind_q <= kind_t'(req.kind);
						val_q <= req.item_value;
						found_q <= 1'b0;
						idx_q <= '0;
						case (kind_t'(req.kind))
							K_APPEND: begin
								equal_q <= 1'b0;
								if (cnt_q == CNT_W'(MAX_ITEMS)) begin
									status_q <= ST_FULL;
									state_q <= S_DONE;
								end else begin
									status_q <= ST_OK;
									r_q <= '0;
									bit_q <= BIT_W'(HASH_W - 1);
									addv_q <= req.item_value;
									state_q <= S_MUL;
								end
							end
							K_FIND, K_REMOVE: begin
								equal_q <= 1'b0;
								if (cnt_q == '0) begin
									status_q <= (kind_t'(req.kind) == K_REMOVE)
										? ST_ABSENT : ST_OK;
									state_q <= S_DONE;
								end else begin
									status_q <= ST_OK;
									state_q <= S_SCAN_RD;
								end
							end
							default: begin
								status_q <= ST_OK;
								equal_q <= {1'b0, req.other_length} == 8'(cnt_q)
									&& req.other_hash == hash_q;
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_SCAN_RD: state_q <= S_SCAN_CMP;
				S_SCAN_CMP: begin
					if (ram_rdata == val_q) begin
						if (kind_q == K_FIND) begin
							found_q <= 1'b1;
							state_q <= S_DONE;
						end else if (idx_inc < cnt_q) begin
							state_q <= S_SH_RD;
						end else begin
							state_q <= S_REH;
						end
					end else if (idx_inc == cnt_q) begin
						if (kind_q == K_REMOVE) begin
							status_q <= ST_ABSENT;
						end
						state_q <= S_DONE;
					end else begin
						idx_q <= idx_inc;
						state_q <= S_SCAN_RD;
					end
				end
				S_SH_RD: state_q <= S_SH_WR;
				S_SH_WR: begin
					idx_q <= idx_inc;
					// The last slot to fill is count minus two.
					state_q <= (idx_inc + 1'b1 < cnt_q) ? S_SH_RD : S_REH;
				end
				S_REH: begin
					cnt_q <= cnt_q - 1'b1;
					hash_q <= '0;
					idx_q <= '0;
					state_q <= (cnt_q == CNT_W'(1)) ? S_DONE : S_H_RD;
				end
				S_H_RD: state_q <= S_H_LD;
				S_H_LD: begin
					addv_q <= ram_rdata;
					r_q <= '0;
					bit_q <= BIT_W'(HASH_W - 1);
					state_q <= S_MUL;
				end
				S_MUL: begin
					// Shift-add over the base bits, most significant first.
					r_q <= mul_red;
					if (bit_q == '0) begin
						state_q <= S_ADD;
					end else begin
						bit_q <= bit_q - 1'b1;
					end
				end
				S_ADD: begin
					hash_q <= add_red;
					if (kind_q == K_APPEND) begin
						cnt_q <= cnt_q + 1'b1;
						state_q <= S_DONE;
					end else begin
						idx_q <= idx_inc;
						state_q <= (idx_inc == cnt_q) ? S_DONE : S_H_RD;
					end
				end
				S_DONE: begin
					if (!outv_q || rsp.ready) begin
						outv_q <= 1'b1;
						ost_q <= status_q;
						ofound_q <= found_q;
						oequal_q <= equal_q;
						olength_q <= 7'(cnt_q);
						ohash_out_q <= hash_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`HLS_ASSERT_NEVER(a_cnt_range, cnt_q > CNT_W'(MAX_ITEMS))
	`HLS_ASSERT_NEVER(a_hash_range, state_q == S_IDLE && hash_q >= HASH_MOD)
	`HLS_ASSERT(a_mul_runs, state_q == S_MUL && bit_q != '0 |=> state_q == S_MUL)
	`HLS_ASSERT(a_append_grows, state_q == S_ADD && kind_q == K_APPEND |=> cnt_q == $past(cnt_q) + 1'b1)
endmodule
